### rtl/core/rrc_pkg.sv
// ----------------------------------------------------------------------------
// rrc_pkg
// Shared types and codes for the rational ratio comparator: sequencer
// states, order codes and the divider status bundle.
// ----------------------------------------------------------------------------
package rrc_pkg;

  // two's complement order codes
  localparam logic [1:0] ORDER_LESS    = 2'b11;
  localparam logic [1:0] ORDER_EQUAL   = 2'b00;
  localparam logic [1:0] ORDER_GREATER = 2'b01;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LSTART,
    S_LWAIT,
    S_RSTART,
    S_RWAIT,
    S_DECIDE,
    S_OUT
  } rrc_state_t;

  // status from the shared divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // reverse the sense of an order code
  function automatic logic [1:0] order_flip(input logic [1:0] code);
    logic [1:0] res;
    res = code;
    if (code == ORDER_LESS) res = ORDER_GREATER;
    else if (code == ORDER_GREATER) res = ORDER_LESS;
    return res;
  endfunction

endpackage

### rtl/core/rrc_divider.sv
// ----------------------------------------------------------------------------
// rrc_divider
// Restoring radix-2 divider, one quotient bit per cycle. A start pulse loads
// the operands; quotient and remainder hold after done until the next start.
// ----------------------------------------------------------------------------
module rrc_divider #(
  parameter int W = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [W-1:0]         dividend,
  input  logic [W-1:0]         divisor,
  output logic [W-1:0]         quot,
  output logic [W-1:0]         rem,
  output rrc_pkg::div_status_t status
);
  import rrc_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic [W-1:0]  dsr;
  logic          busy;
  logic          done;
  logic [W:0]    trial;
  logic [W:0]    diff;

  // trial subtract of the shifted partial remainder
  assign trial = {rem, quot[W-1]};
  assign diff  = trial - {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      dsr  <= divisor;
    end else if (busy) begin
      if (!diff[W]) begin
        rem  <= diff[W-1:0];
        quot <= {quot[W-2:0], 1'b1};
      end else begin
        rem  <= trial[W-1:0];
        quot <= {quot[W-2:0], 1'b0};
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

### rtl/core/rational_ratio_comparator.sv
// ----------------------------------------------------------------------------
// rational_ratio_comparator
// Orders two non-negative fractions by lock-step continued fraction
// expansion, without cross products.
// ----------------------------------------------------------------------------
// One word in, one word out. Each word carries two fractions; order gives
// -1, 0 or +1 for left smaller, equal, left larger, and 0 whenever either
// denominator (low VALUE_WIDTH bits) is zero. One serial divider, a quotient
// bit per cycle, is shared by both sides, left side first, at each continued
// fraction level; a word takes as many levels as its expansions need (about
// 93 at most for 64-bit values). A zero denominator goes straight to the
// result without the divider. No new word is taken until the result has
// been taken.
module rational_ratio_comparator #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] left_num,
  input  logic [63:0] left_den,
  input  logic [63:0] right_num,
  input  logic [63:0] right_den,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [1:0] order
);
  import rrc_pkg::*;

  localparam int VW = VALUE_WIDTH;

  rrc_state_t  state, state_next;
  logic [VW-1:0] ln, ld, rn, rd;
  logic [VW-1:0] lq, lr;
  logic          flip;
  logic [1:0]    result;
  logic          div_start;
  logic [VW-1:0] div_a, div_b, div_q, div_r;
  div_status_t   div_st;
  logic          in_acc;
  logic          zero_den;
  logic          decided;
  logic [1:0]    sense;

  assign in_acc   = in_valid && !in_stall;
  assign zero_den = (left_den[VW-1:0] == '0) || (right_den[VW-1:0] == '0);

  // shared divider, left side first then right
  assign div_a = (state == S_LSTART) ? ln : rn;
  assign div_b = (state == S_LSTART) ? ld : rd;

  rrc_divider #(.W(VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quot     (div_q),
    .rem      (div_r),
    .status   (div_st)
  );

  // level decision from both quotients and remainders
  always_comb begin
    decided = 1'b1;
    sense   = ORDER_EQUAL;
    if (lq != div_q) begin
      sense = (lq < div_q) ? ORDER_LESS : ORDER_GREATER;
    end else if (lr == '0 || div_r == '0) begin
      if (lr == div_r) sense = ORDER_EQUAL;
      else sense = (lr == '0) ? ORDER_LESS : ORDER_GREATER;
    end else begin
      decided = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = zero_den ? S_OUT : S_LSTART;
      S_LSTART: state_next = S_LWAIT;
      S_LWAIT:  if (div_st.done) state_next = S_RSTART;
      S_RSTART: state_next = S_RWAIT;
      S_RWAIT:  if (div_st.done) state_next = S_DECIDE;
      S_DECIDE: state_next = decided ? S_OUT : S_LSTART;
      S_OUT:    if (!out_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // handshake and divider control
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    div_start = 1'b0;
    unique case (state)
      S_IDLE:   in_stall = 1'b0;
      S_LSTART: div_start = 1'b1;
      S_RSTART: div_start = 1'b1;
      S_OUT:    out_valid = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ln     <= left_num[VW-1:0];
      ld     <= left_den[VW-1:0];
      rn     <= right_num[VW-1:0];
      rd     <= right_den[VW-1:0];
      flip   <= 1'b0;
      result <= ORDER_EQUAL;
    end
    if (state == S_LWAIT && div_st.done) begin
      lq <= div_q;
      lr <= div_r;
    end
    if (state == S_DECIDE) begin
      if (decided) begin
        result <= flip ? order_flip(sense) : sense;
      end else begin
        // step to the reciprocals of the remainders
        ln   <= ld;
        ld   <= lr;
        rn   <= rd;
        rd   <= div_r;
        flip <= !flip;
      end
    end
  end

  assign order = result;

endmodule

### rtl/core/rrc_checker.sv
// ----------------------------------------------------------------------------
// rrc_checker
// Port-level checks for the rational ratio comparator, bound to the top.
// ----------------------------------------------------------------------------
module rrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [63:0] left_den,
  input logic [63:0] right_den,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  order
);
  import rrc_pkg::*;

  // a result never carries the unused code
  a_order_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (order == ORDER_LESS || order == ORDER_EQUAL ||
                   order == ORDER_GREATER))
    else $error("order code out of range");

  // no new word while a result waits
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // an accepted word closes the input
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open after accept");

  // zero denominator answers equal at once
  a_zero_den: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (left_den == 64'd0 || right_den == 64'd0))
    |=> (out_valid && order == ORDER_EQUAL))
    else $error("zero denominator not answered as equal");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(order)))
    else $error("stalled result changed");

endmodule

bind rational_ratio_comparator rrc_checker u_rrc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .left_den  (left_den),
  .right_den (right_den),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .order     (order)
);

### tb/tb_rational_ratio_comparator.sv
// ----------------------------------------------------------------------------
// tb_rational_ratio_comparator
// Self-checking bench for the rational ratio comparator. Each accepted word
// is ordered by a continued fraction predictor in the bench, and every
// result is compared in order. Stimulus covers zero denominators and
// numerators, extreme values, equal ratios at different scales, near-equal
// ratios and deep Fibonacci expansions, with random idling on both sides.
// ----------------------------------------------------------------------------

typedef struct {
  bit [63:0]  lnum;
  bit [63:0]  lden;
  bit [63:0]  rnum;
  bit [63:0]  rden;
  logic [1:0] order;
} order_expectation_t;

class order_scoreboard;
  order_expectation_t expected_orders[$];
  bit [63:0]          value_mask;
  int                 failures_seen;

  function new(int width);
    value_mask    = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
    failures_seen = 0;
  endfunction

  // lock-step continued fraction expansion of both ratios
  function logic [1:0] ratio_order(bit [63:0] ln, bit [63:0] ld,
                                   bit [63:0] rn, bit [63:0] rd);
    bit [63:0]  lq, rq, lr, rr;
    bit         inverted;
    bit         decided;
    logic [1:0] sense;
    inverted = 1'b0;
    decided  = 1'b0;
    sense    = rrc_pkg::ORDER_EQUAL;
    if (ld == 0 || rd == 0) return rrc_pkg::ORDER_EQUAL;
    while (!decided) begin
      lq = ln / ld;
      rq = rn / rd;
      if (lq != rq) begin
        sense   = (lq < rq) ? rrc_pkg::ORDER_LESS : rrc_pkg::ORDER_GREATER;
        decided = 1'b1;
      end else begin
        lr = ln % ld;
        rr = rn % rd;
        if (lr == 0 || rr == 0) begin
          if (lr == rr) sense = rrc_pkg::ORDER_EQUAL;
          else if (lr == 0) sense = rrc_pkg::ORDER_LESS;
          else sense = rrc_pkg::ORDER_GREATER;
          decided = 1'b1;
        end else begin
          // step to the reciprocals of the remainders
          ln       = ld;
          ld       = lr;
          rn       = rd;
          rd       = rr;
          inverted = !inverted;
        end
      end
    end
    if (inverted && sense == rrc_pkg::ORDER_LESS) return rrc_pkg::ORDER_GREATER;
    if (inverted && sense == rrc_pkg::ORDER_GREATER) return rrc_pkg::ORDER_LESS;
    return sense;
  endfunction

  function void note_word(bit [63:0] lnum, bit [63:0] lden,
                          bit [63:0] rnum, bit [63:0] rden);
    order_expectation_t e;
    e.lnum  = lnum & value_mask;
    e.lden  = lden & value_mask;
    e.rnum  = rnum & value_mask;
    e.rden  = rden & value_mask;
    e.order = ratio_order(e.lnum, e.lden, e.rnum, e.rden);
    expected_orders.push_back(e);
  endfunction

  function void check_order(logic [1:0] got);
    order_expectation_t e;
    if (expected_orders.size() == 0) begin
      failures_seen++;
      if (failures_seen <= 10)
        $display("unexpected order word: got %0d", $signed(got));
      return;
    end
    e = expected_orders.pop_front();
    if (got !== e.order) begin
      failures_seen++;
      if (failures_seen <= 10)
        $display("order mismatch for %0d/%0d vs %0d/%0d: expected %0d got %0d",
                 e.lnum, e.lden, e.rnum, e.rden, $signed(e.order), $signed(got));
    end
  endfunction

  function int pending();
    return expected_orders.size();
  endfunction

  function int failures();
    return failures_seen + expected_orders.size();
  endfunction
endclass

module tb_rational_ratio_comparator;
  import rrc_pkg::*;

  localparam int        VALUE_WIDTH = 64;
  localparam int        IDLE_PCT    = 25;
  localparam int        RANDOM_WORDS = 80;
  // worst word: ~93 levels, plus gaps, stalls, margin
  localparam longint    CYCLE_LIMIT = 8_000_000;
  localparam bit [63:0] MAXV        = '1;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] left_num;
  logic [63:0] left_den;
  logic [63:0] right_num;
  logic [63:0] right_den;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [1:0] order;

  order_scoreboard sb;
  bit [63:0]       fib [0:93];
  bit              quiet = 1'b0;
  longint          cycles = 0;

  rational_ratio_comparator #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .left_num (left_num),
    .left_den (left_den),
    .right_num(right_num),
    .right_den(right_den),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .order    (order)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_rational_ratio_comparator NOT OK");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= !rst && !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // result check
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_order(order);
  end

  function automatic bit sender_idle();
    return !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // present one word and hold it until taken
  task automatic send_word(bit [63:0] lnum, bit [63:0] lden,
                           bit [63:0] rnum, bit [63:0] rden);
    @(negedge clk);
    while (sender_idle()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    left_num  <= lnum;
    left_den  <= lden;
    right_num <= rnum;
    right_den <= rden;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_word(lnum, lden, rnum, rden);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic bit [63:0] pick_edge_value();
    case ($urandom_range(0, 4))
      0: return 64'd0;
      1: return 64'd1;
      2: return MAXV;
      3: return MAXV - 64'd1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic bit [63:0] wide_random();
    bit [63:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 1)) v = v >> $urandom_range(0, 63);
    return v;
  endfunction

  task automatic random_word();
    bit [63:0] a, b, k1, k2, ln, ld, rn, rd;
    int        kind, i;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        ln = wide_random();
        ld = wide_random();
        rn = wide_random();
        rd = wide_random();
      end
      2, 3, 4, 5, 6: begin
        // same ratio at two scales, optionally nudged off by one
        a  = 64'($urandom);
        b  = 64'($urandom);
        k1 = 64'($urandom_range(1, 32'hffff_ffff));
        k2 = 64'($urandom_range(1, 32'hffff_ffff));
        ln = a * k1;
        ld = b * k1;
        rn = a * k2;
        rd = b * k2;
        if (kind >= 5) begin
          if ($urandom_range(0, 1)) rn = rn + 64'($urandom_range(0, 2)) - 64'd1;
          else rd = rd + 64'($urandom_range(0, 2)) - 64'd1;
        end
      end
      7: begin
        // consecutive fibonacci ratios expand to the deepest levels
        i  = $urandom_range(2, 92);
        ln = fib[i + 1];
        ld = fib[i];
        rn = fib[i];
        rd = fib[i - 1];
        if ($urandom_range(0, 3) == 0) begin
          rn = ln;
          rd = ld;
        end else if ($urandom_range(0, 1)) begin
          {ln, ld, rn, rd} = {rn, rd, ln, ld};
        end
      end
      8: begin
        ln = 64'($urandom_range(0, 7));
        ld = 64'($urandom_range(0, 7));
        rn = 64'($urandom_range(0, 7));
        rd = 64'($urandom_range(0, 7));
      end
      default: begin
        ln = pick_edge_value();
        ld = pick_edge_value();
        rn = pick_edge_value();
        rd = pick_edge_value();
      end
    endcase
    send_word(ln, ld, rn, rd);
  endtask

  initial begin
    sb        = new(VALUE_WIDTH);
    rst       = 1'b1;
    in_valid  = 1'b0;
    left_num  = '0;
    left_den  = '0;
    right_num = '0;
    right_den = '0;
    fib[0] = 64'd0;
    fib[1] = 64'd1;
    for (int n = 2; n <= 93; n++) fib[n] = fib[n - 1] + fib[n - 2];

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words: zero denominators, zero numerators, extremes
    send_word(64'd0, 64'd0, 64'd0, 64'd0);
    send_word(64'd5, 64'd0, 64'd3, 64'd7);
    send_word(64'd3, 64'd7, 64'd5, 64'd0);
    send_word(MAXV, 64'd0, MAXV, 64'd0);
    send_word(64'd0, 64'd1, 64'd0, MAXV);
    send_word(64'd0, 64'd1, 64'd1, 64'd1);
    send_word(64'd1, 64'd1, 64'd0, 64'd5);
    send_word(MAXV, MAXV, MAXV, MAXV);
    send_word(MAXV, 64'd1, MAXV - 64'd1, 64'd1);
    send_word(64'd1, MAXV, 64'd1, MAXV - 64'd1);
    send_word(MAXV, MAXV - 64'd1, MAXV - 64'd1, MAXV - 64'd2);
    send_word(64'd1, 64'd2, 64'd2, 64'd4);
    // equal quotients, one remainder zero
    send_word(64'd3, 64'd1, 64'd7, 64'd2);
    send_word(64'd7, 64'd2, 64'd6, 64'd2);
    // decision after one reciprocal step
    send_word(64'd7, 64'd2, 64'd10, 64'd3);
    send_word(64'd10, 64'd3, 64'd7, 64'd2);
    // deepest expansions
    send_word(fib[93], fib[92], fib[92], fib[91]);
    send_word(fib[92], fib[91], fib[93], fib[92]);
    send_word(fib[93], fib[92], fib[93], fib[92]);
    send_word(MAXV, 64'd1, 64'd0, 64'd1);

    // let the block drain before the random part
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      quiet = (n >= 40 && n < 70);
      if (n == 75) begin
        // drop valid so the last word is not taken twice while draining
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
      end
      random_word();
    end
    quiet = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    wait_drained();
    repeat (300) @(posedge clk);
    if (sb.failures() == 0) $display("tb_rational_ratio_comparator OK");
    else $display("tb_rational_ratio_comparator NOT OK");
    $finish;
  end

endmodule

### files.f
rtl/core/rrc_pkg.sv
rtl/core/rrc_divider.sv
rtl/core/rational_ratio_comparator.sv
rtl/core/rrc_checker.sv
tb/tb_rational_ratio_comparator.sv
